FILE: hdl/fir_q15_filter_23tap_unit_assert.svh
// Assertion macros shared by the filter RTL.
`ifndef FIR_Q15_FILTER_23TAP_UNIT_ASSERT_SVH
`define FIR_Q15_FILTER_23TAP_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Checks that a condition holds at every clock edge out of reset.
`define FQF_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Checks that a trigger in one cycle is followed by a condition in the next.
`define FQF_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`else

`define FQF_ASSERT(lbl, cond)
`define FQF_ASSERT_NEXT(lbl, trig, cond)

`endif

`endif

FILE: hdl/fqf_pkg.sv
package fqf_pkg;

    localparam int TAPS       = 23;
    localparam int COEF_COUNT = 23;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int CNT_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
    // Each product fits in 31 bits; the extra bits cover the sum over all taps.
    localparam int ACC_W      = PROD_W + CNT_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [CNT_W-1:0]           tap_cnt_t;

    // Symmetric Q15 coefficients; taps past the table use zero.
    function automatic coef_t coef(input int k);
        coef_t c;
        c = '0;
        if (k < COEF_COUNT)
        begin
            unique case (k)
                0, 22:   c = 16'sd434;
                1, 21:   c = 16'sd143;
                2, 20:   c = -16'sd738;
                3, 19:   c = -16'sd1193;
                4, 18:   c = -16'sd153;
                5, 17:   c = 16'sd1287;
                6, 16:   c = 16'sd682;
                7, 15:   c = -16'sd1940;
                8, 14:   c = -16'sd2591;
                9, 13:   c = 16'sd2233;
                10, 12:  c = 16'sd10089;
                11:      c = 16'sd13988;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

FILE: hdl/fqf_sample_if.sv
interface fqf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_filtered;
    logic signed [15:0] sample_passed;

    modport source (output valid, output sample_filtered, output sample_passed, input ready);
    modport sink (input valid, input sample_filtered, input sample_passed, output ready);
endinterface

FILE: hdl/fqf_result_if.sv
interface fqf_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] filtered_out;
    logic signed [15:0] passed_out;

    modport source (output valid, output filtered_out, output passed_out, input ready);
    modport sink (input valid, input filtered_out, input passed_out, output ready);
endinterface

FILE: hdl/fir_q15_filter_23tap_unit.sv
// Symmetric 23-tap Q15 FIR filter on sample pairs. The first sample of each item
// enters a delay line that is zero after reset; the filtered result is the exact
// sum of products shifted right by 15 and wrapped to 16 bits, with no saturation.
// The second sample is returned unchanged alongside it. One shared 16x16
// multiplier walks the delay line, which rotates one tap word per cycle past it.
// An accepted item passes through the run, drain and done states before the next
// item can be accepted, provided the previous result has been taken. A result
// waits in the output register while the next item is being filtered.
`include "fir_q15_filter_23tap_unit_assert.svh"

module fir_q15_filter_23tap_unit (
    input  logic         clk,
    input  logic         rst_n,
    fqf_sample_if.sink   sample_ch,
    fqf_result_if.source result_ch
);
    import fqf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t   state_reg;
    sample_t  dl_reg [TAPS];
    tap_cnt_t cnt_reg;
    prod_t    prod_reg;
    logic     prod_valid_reg;
    acc_t     acc_reg;
    sample_t  pass_reg;
    logic     out_valid_reg;
    sample_t  filtered_reg;
    sample_t  passed_reg;

    logic accept;
    logic out_take;
    logic out_free;

    assign sample_ch.ready    = (state_reg == ST_IDLE);
    assign accept             = sample_ch.valid && sample_ch.ready;
    assign out_take           = result_ch.valid && result_ch.ready;
    assign out_free           = !out_valid_reg || result_ch.ready;
    assign result_ch.valid    = out_valid_reg;
    assign result_ch.filtered_out = filtered_reg;
    assign result_ch.passed_out   = passed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            for (int k = 0; k < TAPS; k++)
            begin
                dl_reg[k] <= '0;
            end
            cnt_reg        <= '0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // A new result may replace the one being taken in the same cycle.
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        for (int k = TAPS - 1; k > 0; k--)
                        begin
                            dl_reg[k] <= dl_reg[k-1];
                        end
                        dl_reg[0] <= sample_ch.sample_filtered;
                        pass_reg  <= sample_ch.sample_passed;
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    // The head of the ring always holds the tap that cnt_reg names;
                    // after TAPS rotations the line is back in its original order.
                    prod_reg       <= prod_t'(dl_reg[0]) * prod_t'(coef(int'(cnt_reg)));
                    prod_valid_reg <= 1'b1;
                    for (int k = 0; k < TAPS - 1; k++)
                    begin
                        dl_reg[k] <= dl_reg[k+1];
                    end
                    dl_reg[TAPS-1] <= dl_reg[0];
                    if (prod_valid_reg)
                    begin
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    end
                    if (cnt_reg == CNT_W'(TAPS - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    acc_reg        <= acc_reg + ACC_W'(prod_reg);
                    prod_valid_reg <= 1'b0;
                    state_reg      <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        filtered_reg  <= acc_reg[30:15];
                        passed_reg    <= pass_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `FQF_ASSERT_NEXT(a_accept_starts_run, accept, state_reg == ST_RUN && cnt_reg == '0)
    `FQF_ASSERT(a_cnt_in_range, cnt_reg <= CNT_W'(TAPS - 1))
    `FQF_ASSERT(a_prod_only_busy, !prod_valid_reg || state_reg == ST_RUN || state_reg == ST_DRAIN)
    `FQF_ASSERT_NEXT(a_drain_clears_prod, state_reg == ST_DRAIN, !prod_valid_reg && state_reg == ST_DONE)
    `FQF_ASSERT_NEXT(a_done_loads_out, state_reg == ST_DONE && out_free, out_valid_reg && state_reg == ST_IDLE)

endmodule
